// ===== src/grid_ray_caster_dda_macros.svh =====
// Assertion macros shared by the grid ray caster files.
// Each macro samples on clock and is disabled while reset is high.
`ifndef GRID_RAY_CASTER_DDA_MACROS_SVH
`define GRID_RAY_CASTER_DDA_MACROS_SVH

// The condition holds at every clock edge.
`define GRC_ASSERT_HOLDS(name, cond) \
   name: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("grid ray caster check failed");

// When the trigger holds, the condition holds in the next cycle.
`define GRC_ASSERT_NEXT(name, trig, cond) \
   name: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error("grid ray caster check failed");

`endif

// ===== src/grc_pkg.sv =====
// Shared constants, the queued item type and the sine table function of the ray caster.
// Used by every module of the block; depends on nothing else.
package grc_pkg;

   localparam int TILE_PIXELS  = 64;
   localparam int TILE_SHIFT   = $clog2(TILE_PIXELS);
   localparam int MAX_MAP_SIDE = 64;
   localparam int CELL_BITS    = $clog2(MAX_MAP_SIDE);
   localparam int LIMIT_W      = 7;
   localparam int ANGLE_STEPS  = 1024;
   localparam int ANGLE_BITS   = $clog2(ANGLE_STEPS);
   localparam int FOLD_BITS    = ANGLE_BITS - 2;
   localparam int FOLD_STEPS   = 1 << FOLD_BITS;
   localparam int PHASE_SHIFT  = 24 - ANGLE_BITS;
   localparam int POS_W        = 12;
   localparam int DIR_W        = 16;
   localparam int MAG_W        = 15;
   localparam int DIR_ONE      = 16384;
   localparam int DELTA_W      = 24;
   localparam int QUO_W        = 23;
   localparam int DIVIDEND_MSB = 22;
   localparam int FRAC_Q       = 22;
   localparam int SIDE_W       = 40;
   localparam int COORD_W      = 14;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

   localparam logic [DELTA_W-1:0] DELTA_MAX = '1;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_CAST  = 1'b1;

   localparam logic [0:0] CSR_MAP_WIDTH  = 1'b0;
   localparam logic [0:0] CSR_MAP_HEIGHT = 1'b1;

   localparam logic [1:0] FACE_NORTH = 2'd0;
   localparam logic [1:0] FACE_SOUTH = 2'd1;
   localparam logic [1:0] FACE_EAST  = 2'd2;
   localparam logic [1:0] FACE_WEST  = 2'd3;

   localparam longint unsigned C1 = 64'd1686629713;
   localparam longint unsigned C3 = 64'd693598668;
   localparam longint unsigned C5 = 64'd85569305;
   localparam longint unsigned C7 = 64'd5026995;
   localparam longint unsigned C9 = 64'd172272;

   typedef struct packed {
      logic                     op;
      logic signed [DIR_W-1:0]  dir_x;
      logic signed [DIR_W-1:0]  dir_y;
      logic [POS_W-1:0]         pos_x;
      logic [POS_W-1:0]         pos_y;
      logic [CELL_BITS-1:0]     cell_x;
      logic [CELL_BITS-1:0]     cell_y;
      logic                     wall;
   } item_type;

   // Quarter-wave sine magnitude in Q1.14 for fold index k; evaluated at
   // elaboration only, with a degree-9 odd polynomial in Q30.
   function automatic logic [MAG_W-1:0] sin_mag(input int k);
      longint unsigned x;
      longint unsigned z;
      longint unsigned z2;
      longint unsigned a;
      longint unsigned s;
      x  = 64'(k) << PHASE_SHIFT;
      z  = x << 8;
      z2 = (z * z) >> 30;
      a  = C7 - ((z2 * C9) >> 30);
      a  = C5 - ((z2 * a) >> 30);
      a  = C3 - ((z2 * a) >> 30);
      a  = C1 - ((z2 * a) >> 30);
      s  = (z * a) >> 30;
      s  = (s + 64'd32768) >> 16;
      if (s > 64'(DIR_ONE)) s = 64'(DIR_ONE);
      return MAG_W'(s);
   endfunction

endpackage

// ===== src/grc_front.sv =====
// Front end: turns an incoming item into a queue entry, looking up the ray direction.
// Depends on grc_pkg for the item type and the sine table.
module grc_front
   import grc_pkg::*;
(
   input  logic                  req_operation,
   input  logic [ANGLE_BITS-1:0] req_angle_index,
   input  logic [POS_W-1:0]      req_pos_x,
   input  logic [POS_W-1:0]      req_pos_y,
   input  logic [CELL_BITS-1:0]  req_cell_x,
   input  logic [CELL_BITS-1:0]  req_cell_y,
   input  logic                  req_wall,
   output item_type              item
);

   logic [MAG_W-1:0]      sin_rom [FOLD_STEPS];
   logic [ANGLE_BITS-1:0] lane_angle [2];
   logic signed [DIR_W-1:0] lane_dir [2];

   for (genvar i = 0; i < FOLD_STEPS; i++) begin : g_rom
      assign sin_rom[i] = sin_mag(i);
   end

   // Lane 0 gives the sine (y), lane 1 the cosine as the sine a quarter turn on.
   assign lane_angle[0] = req_angle_index;
   assign lane_angle[1] = req_angle_index + ANGLE_BITS'(FOLD_STEPS);

   for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [1:0]           quad;
      logic [FOLD_BITS-1:0] u;
      logic [FOLD_BITS:0]   k;
      logic [MAG_W-1:0]     mag;
      always_comb begin
         quad = lane_angle[l][ANGLE_BITS-1 -: 2];
         u    = lane_angle[l][FOLD_BITS-1:0];
         k    = quad[0] ? ((FOLD_BITS+1)'(FOLD_STEPS) - {1'b0, u}) : {1'b0, u};
         mag  = k[FOLD_BITS] ? MAG_W'(DIR_ONE) : sin_rom[k[FOLD_BITS-1:0]];
         lane_dir[l] = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      end
   end

   always_comb begin
      item.op     = req_operation;
      item.dir_y  = lane_dir[0];
      item.dir_x  = lane_dir[1];
      item.pos_x  = req_pos_x;
      item.pos_y  = req_pos_y;
      item.cell_x = req_cell_x;
      item.cell_y = req_cell_y;
      item.wall   = req_wall;
   end

endmodule

// ===== src/grc_queue.sv =====
// Short first-in first-out queue between the front end and the ray walker.
// Depends on grc_pkg for the item type and depth.
module grc_queue
   import grc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output item_type head_item,
   output logic     empty,
   output logic     full
);

   item_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   assign empty     = (count_ff == '0);
   assign full      = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign head_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_item;
   end

endmodule

// ===== src/grc_div.sv =====
// Restoring divider giving 2^22 over a Q1.14 magnitude, one quotient bit per cycle.
// Depends on grc_pkg for widths.
module grc_div
   import grc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [MAG_W-1:0] divisor,
   output logic             done,
   output logic [QUO_W-1:0] quotient
);

   logic [MAG_W:0]   rem_ff, rem_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [MAG_W-1:0] div_ff, div_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [MAG_W:0]   rem_sh;
   logic             fits;

   assign done     = done_ff;
   assign quotient = quo_ff;

   always_comb begin
      rem_sh  = {rem_ff[MAG_W-1:0], (cnt_ff == 5'(DIVIDEND_MSB))};
      fits    = (rem_sh >= {1'b0, div_ff});
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = '0;
         div_in = divisor;
         cnt_in = 5'(DIVIDEND_MSB);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = fits ? rem_sh - {1'b0, div_ff} : rem_sh;
         quo_in = {quo_ff[QUO_W-2:0], fits};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

endmodule

// ===== src/grc_back.sv =====
// Back end: holds the wall map, runs setup and the cell walk, and drives the result register.
// Depends on grc_pkg and instantiates grc_div.
module grc_back
   import grc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic [LIMIT_W-1:0]         limit_x,
   input  logic [LIMIT_W-1:0]         limit_y,
   input  item_type                   head_item,
   input  logic                       queue_empty,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [DELTA_W-1:0]         rsp_distance,
   output logic signed [COORD_W-1:0]  rsp_hit_x,
   output logic signed [COORD_W-1:0]  rsp_hit_y,
   output logic                       rsp_hit_side,
   output logic [1:0]                 rsp_wall_facing
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DIVX  = 4'd1;
   localparam logic [3:0] S_DIVY  = 4'd2;
   localparam logic [3:0] S_SIDEX = 4'd3;
   localparam logic [3:0] S_SIDEY = 4'd4;
   localparam logic [3:0] S_WALK  = 4'd5;
   localparam logic [3:0] S_PERP  = 4'd6;
   localparam logic [3:0] S_MUL   = 4'd7;
   localparam logic [3:0] S_SUM   = 4'd8;

   localparam int ADDR_W = 2 * CELL_BITS;
   localparam int MX_W   = CELL_BITS + 2;
   localparam int OFF_W  = POS_W + 2;
   localparam int PROD_W = 33 + DIR_W;
   localparam int V_W    = PROD_W + TILE_SHIFT + 1;

   logic [3:0]              state_ff, state_in;
   logic signed [DIR_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [POS_W-1:0]        px_ff, px_in, py_ff, py_in;
   logic signed [MX_W-1:0]  mx_ff, mx_in, my_ff, my_in;
   logic [DELTA_W-1:0]      ddx_ff, ddx_in, ddy_ff, ddy_in;
   logic [SIDE_W-1:0]       sx_ff, sx_in, sy_ff, sy_in;
   logic [SIDE_W-1:0]       perp_ff, perp_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                    side_ff, side_in;
   logic                    first_ff, first_in;
   logic                    out_ff, out_in;
   logic                    rd_ff;

   logic                    wall_mem [1 << ADDR_W];
   logic                    mem_we;
   logic [ADDR_W-1:0]       mem_waddr, mem_raddr;

   logic                    div_start, div_done;
   logic [MAG_W-1:0]        div_divisor;
   logic [QUO_W-1:0]        div_quotient;

   logic                    out_free, load_rsp;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [DELTA_W-1:0]      dist_ff, dist_in;
   logic signed [COORD_W-1:0] hx_ff, hx_in, hy_ff, hy_in;
   logic                    hside_ff;
   logic [1:0]              face_ff, face_in;

   // Step and setup helpers.
   logic                    take_x;
   logic signed [MX_W-1:0]  mx_step, my_step;
   logic signed [OFF_W-1:0] off_raw;
   logic [POS_W:0]          off_val;
   logic [DELTA_W-1:0]      off_delta;
   logic [POS_W+DELTA_W:0]  side_prod;
   logic [31:0]             perp_cap;
   logic signed [DIR_W-1:0] along_dir;
   logic signed [V_W-1:0]   v_sum, v_adj;
   logic signed [V_W-FRAC_Q-1:0] v_pix;
   logic signed [COORD_W-1:0] along_pix, cross_pix;

   grc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_distance    = dist_ff;
   assign rsp_hit_x       = hx_ff;
   assign rsp_hit_y       = hy_ff;
   assign rsp_hit_side    = hside_ff;
   assign rsp_wall_facing = face_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      // DDA step: advance whichever grid line is nearer.
      take_x  = (sx_ff < sy_ff);
      mx_step = mx_ff;
      my_step = my_ff;
      if (take_x) mx_step = dx_ff[DIR_W-1] ? mx_ff - 2'sd1 : mx_ff + 2'sd1;
      else        my_step = dy_ff[DIR_W-1] ? my_ff - 2'sd1 : my_ff + 2'sd1;

      // Pixel offset to the first grid line on one axis, clamped at zero.
      if (state_ff == S_SIDEX) begin
         off_raw   = dx_ff[DIR_W-1]
            ? $signed({2'b0, px_ff}) - $signed({mx_ff, TILE_SHIFT'(0)})
            : $signed({mx_ff + 2'sd1, TILE_SHIFT'(0)}) - $signed({2'b0, px_ff});
         off_delta = ddx_ff;
      end else begin
         off_raw   = dy_ff[DIR_W-1]
            ? $signed({2'b0, py_ff}) - $signed({my_ff, TILE_SHIFT'(0)})
            : $signed({my_ff + 2'sd1, TILE_SHIFT'(0)}) - $signed({2'b0, py_ff});
         off_delta = ddy_ff;
      end
      off_val   = off_raw[OFF_W-1] ? '0 : off_raw[POS_W:0];
      side_prod = off_val * off_delta;

      perp_cap  = (perp_ff[SIDE_W-1:32] != '0) ? '1 : perp_ff[31:0];
      along_dir = side_ff ? dx_ff : dy_ff;

      // Hit point along the ray in Q22 pixels, truncated toward zero.
      v_sum = $signed({1'b0, (side_ff ? px_ff : py_ff), FRAC_Q'(0)})
            + (V_W'(prod_ff) <<< TILE_SHIFT);
      v_adj = v_sum[V_W-1] ? v_sum + V_W'((1 << FRAC_Q) - 1) : v_sum;
      v_pix = v_adj[V_W-1:FRAC_Q];
      if (v_pix > (V_W-FRAC_Q)'(8191))
         along_pix = COORD_W'(8191);
      else if (v_pix < -(V_W-FRAC_Q)'(8192))
         along_pix = -COORD_W'(8192);
      else
         along_pix = v_pix[COORD_W-1:0];

      // Grid line that was crossed, in whole pixels.
      if (!side_ff)
         cross_pix = ($signed(COORD_W'(mx_ff)) <<< TILE_SHIFT)
                   + (dx_ff[DIR_W-1] ? COORD_W'(TILE_PIXELS) : '0);
      else
         cross_pix = ($signed(COORD_W'(my_ff)) <<< TILE_SHIFT)
                   + (dy_ff[DIR_W-1] ? COORD_W'(TILE_PIXELS) : '0);
   end

   always_comb begin
      state_in  = state_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      mx_in     = mx_ff;
      my_in     = my_ff;
      ddx_in    = ddx_ff;
      ddy_in    = ddy_ff;
      sx_in     = sx_ff;
      sy_in     = sy_ff;
      perp_in   = perp_ff;
      prod_in   = prod_ff;
      side_in   = side_ff;
      first_in  = first_ff;
      out_in    = out_ff;
      pop       = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = {head_item.cell_y, head_item.cell_x};
      mem_raddr = {my_step[CELL_BITS-1:0], mx_step[CELL_BITS-1:0]};
      div_start = 1'b0;
      div_divisor = dx_ff[DIR_W-1] ? MAG_W'(-dx_ff) : MAG_W'(dx_ff);
      load_rsp  = 1'b0;
      dist_in   = (perp_ff[SIDE_W-1:DELTA_W-TILE_SHIFT] != '0)
                  ? DELTA_MAX : {perp_ff[DELTA_W-TILE_SHIFT-1:0], TILE_SHIFT'(0)};
      hx_in     = side_ff ? along_pix : cross_pix;
      hy_in     = side_ff ? cross_pix : along_pix;
      if (!side_ff) face_in = (dx_ff > 0) ? FACE_WEST : FACE_EAST;
      else          face_in = (dy_ff > 0) ? FACE_NORTH : FACE_SOUTH;

      unique case (state_ff)
         S_IDLE: begin
            if (!queue_empty) begin
               pop = 1'b1;
               if (head_item.op == OP_WRITE) begin
                  mem_we = 1'b1;
               end else begin
                  dx_in       = head_item.dir_x;
                  dy_in       = head_item.dir_y;
                  px_in       = head_item.pos_x;
                  py_in       = head_item.pos_y;
                  mx_in       = MX_W'(head_item.cell_x);
                  my_in       = MX_W'(head_item.cell_y);
                  div_start   = 1'b1;
                  div_divisor = head_item.dir_x[DIR_W-1]
                                ? MAG_W'(-head_item.dir_x) : MAG_W'(head_item.dir_x);
                  state_in    = S_DIVX;
               end
            end
         end
         S_DIVX: begin
            if (div_done) begin
               ddx_in      = (dx_ff == '0) ? DELTA_MAX : DELTA_W'(div_quotient);
               div_start   = 1'b1;
               div_divisor = dy_ff[DIR_W-1] ? MAG_W'(-dy_ff) : MAG_W'(dy_ff);
               state_in    = S_DIVY;
            end
         end
         S_DIVY: begin
            if (div_done) begin
               ddy_in   = (dy_ff == '0) ? DELTA_MAX : DELTA_W'(div_quotient);
               state_in = S_SIDEX;
            end
         end
         S_SIDEX: begin
            sx_in    = SIDE_W'(side_prod >> TILE_SHIFT);
            state_in = S_SIDEY;
         end
         S_SIDEY: begin
            sy_in    = SIDE_W'(side_prod >> TILE_SHIFT);
            first_in = 1'b1;
            state_in = S_WALK;
         end
         S_WALK: begin
            if (!first_ff && (out_ff || rd_ff)) begin
               state_in = S_PERP;
            end else begin
               first_in = 1'b0;
               mx_in    = mx_step;
               my_in    = my_step;
               side_in  = !take_x;
               if (take_x) sx_in = sx_ff + SIDE_W'(ddx_ff);
               else        sy_in = sy_ff + SIDE_W'(ddy_ff);
               out_in = mx_step[MX_W-1] || (mx_step[LIMIT_W-1:0] >= limit_x)
                     || my_step[MX_W-1] || (my_step[LIMIT_W-1:0] >= limit_y);
            end
         end
         S_PERP: begin
            perp_in  = side_ff ? sy_ff - SIDE_W'(ddy_ff) : sx_ff - SIDE_W'(ddx_ff);
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in  = PROD_W'($signed({1'b0, perp_cap}) * along_dir);
            state_in = S_SUM;
         end
         S_SUM: begin
            if (out_free) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (load_rsp)                    rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      else                             rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         first_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         first_ff     <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      px_ff   <= px_in;
      py_ff   <= py_in;
      mx_ff   <= mx_in;
      my_ff   <= my_in;
      ddx_ff  <= ddx_in;
      ddy_ff  <= ddy_in;
      sx_ff   <= sx_in;
      sy_ff   <= sy_in;
      perp_ff <= perp_in;
      prod_ff <= prod_in;
      side_ff <= side_in;
      out_ff  <= out_in;
      if (load_rsp) begin
         dist_ff  <= dist_in;
         hx_ff    <= hx_in;
         hy_ff    <= hy_in;
         hside_ff <= side_ff;
         face_ff  <= face_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) wall_mem[mem_waddr] <= head_item.wall;
      rd_ff <= wall_mem[mem_raddr];
   end

endmodule

// ===== src/grid_ray_caster_dda.sv =====
// Grid ray caster: the walker handles a write item in its idle state; a cast first runs
// two serial reciprocal divisions as setup and then steps cell by cell, with one
// wall-map read per cell.
// A four-entry queue lets the front accept items while a cast is walking.
// Reset (synchronous, active high) empties the queue, idles the walker, drops any
// pending result and sets both map limits to 64; the wall map itself is not cleared.
`include "grid_ray_caster_dda_macros.svh"

module grid_ray_caster_dda
   import grc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [0:0]                 csr_index,
   input  logic [LIMIT_W-1:0]         csr_write_data,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_operation,
   input  logic [ANGLE_BITS-1:0]      req_angle_index,
   input  logic [POS_W-1:0]           req_pos_x,
   input  logic [POS_W-1:0]           req_pos_y,
   input  logic [CELL_BITS-1:0]       req_cell_x,
   input  logic [CELL_BITS-1:0]       req_cell_y,
   input  logic                       req_wall,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [DELTA_W-1:0]         rsp_distance,
   output logic signed [COORD_W-1:0]  rsp_hit_x,
   output logic signed [COORD_W-1:0]  rsp_hit_y,
   output logic                       rsp_hit_side,
   output logic [1:0]                 rsp_wall_facing
);

   logic [LIMIT_W-1:0] map_width_ff, map_width_in;
   logic [LIMIT_W-1:0] map_height_ff, map_height_in;
   logic [LIMIT_W-1:0] limit_x, limit_y;

   item_type front_item, head_item;
   logic     q_push, q_pop, q_empty, q_full;

   // Configuration registers. Values above the map store act as its full side.
   always_comb begin
      map_width_in  = map_width_ff;
      map_height_in = map_height_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MAP_WIDTH:  map_width_in  = csr_write_data;
            CSR_MAP_HEIGHT: map_height_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= LIMIT_W'(MAX_MAP_SIDE);
         map_height_ff <= LIMIT_W'(MAX_MAP_SIDE);
      end else begin
         map_width_ff  <= map_width_in;
         map_height_ff <= map_height_in;
      end
   end

   assign limit_x = (map_width_ff > LIMIT_W'(MAX_MAP_SIDE))
                    ? LIMIT_W'(MAX_MAP_SIDE) : map_width_ff;
   assign limit_y = (map_height_ff > LIMIT_W'(MAX_MAP_SIDE))
                    ? LIMIT_W'(MAX_MAP_SIDE) : map_height_ff;

   // Every item, writes included, goes through the queue so that a map write
   // never overtakes or falls behind a cast.
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   grc_front u_front (
      .req_operation   (req_operation),
      .req_angle_index (req_angle_index),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_cell_x      (req_cell_x),
      .req_cell_y      (req_cell_y),
      .req_wall        (req_wall),
      .item            (front_item)
   );

   grc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (front_item),
      .pop       (q_pop),
      .head_item (head_item),
      .empty     (q_empty),
      .full      (q_full)
   );

   // The walker owns the wall map, the divider and the result register.
   grc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .limit_x         (limit_x),
      .limit_y         (limit_y),
      .head_item       (head_item),
      .queue_empty     (q_empty),
      .pop             (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_distance    (rsp_distance),
      .rsp_hit_x       (rsp_hit_x),
      .rsp_hit_y       (rsp_hit_y),
      .rsp_hit_side    (rsp_hit_side),
      .rsp_wall_facing (rsp_wall_facing)
   );

   // A vertical-line hit faces east or west, a horizontal one north or south.
   `GRC_ASSERT_HOLDS(a_side_matches_facing, !rsp_valid || (rsp_hit_side == !rsp_wall_facing[1]))
   // An item pushed into an empty queue is visible at the head in the next cycle.
   `GRC_ASSERT_NEXT(a_queue_fills, !reset && q_push && q_empty, !q_empty)
   // A width write lands in the width register.
   `GRC_ASSERT_NEXT(a_width_write, !reset && csr_write_enable && (csr_index == CSR_MAP_WIDTH), map_width_ff == $past(csr_write_data))

endmodule
